[design/xcfr_pkg.sv]
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types, codes and sizes of the XOR-checked frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xcfr_pkg;

	// sizes
	localparam int MAX_PAYLOAD = 16;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 5;
	localparam int IDX_W       = $clog2(MAX_PAYLOAD);
	localparam int TICK_W      = 24;
	localparam int STATUS_W    = 3;
	localparam int OPCODE_W    = 2;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [LEN_W-1:0]  LEN_SAT  = '1;
	localparam logic [TICK_W-1:0] IDLE_MAX = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_TYPE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EVENT_TYPE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STARTED_ID    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STOPPED_ID    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 3'd5;

	typedef enum logic [OPCODE_W-1:0] {
		OP_BYTE   = 2'd0,
		OP_TICK   = 2'd1,
		OP_ARM    = 2'd2,
		OP_CANCEL = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_MATCHED    = 3'd0,
		ST_EVENT      = 3'd1,
		ST_UNEXPECTED = 3'd2,
		ST_OTHER      = 3'd3,
		ST_BAD_SUM    = 3'd4,
		ST_TOO_LONG   = 3'd5,
		ST_TIMEOUT    = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_TYPE = 3'd1,
		PH_ID   = 3'd2,
		PH_LEN  = 3'd3,
		PH_DATA = 3'd4,
		PH_SUM  = 3'd5
	} phase_t;

	typedef logic [MAX_PAYLOAD-1:0][BYTE_W-1:0] payload_t;

	// one finished frame or report, handed from the parser to the emitter
	typedef struct packed {
		status_t            status;
		logic [BYTE_W-1:0]  ftype;
		logic [BYTE_W-1:0]  fid;
		logic [LEN_W-1:0]   len;
		payload_t           payload;
		logic               motor;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

[design/xcfr_item_if.sv]
// ----------------------------------------------------------------------------
// xcfr_item_if
// Input word channel: opcode, line byte and awaited id.
// ----------------------------------------------------------------------------
`default_nettype none

interface xcfr_item_if;
	import xcfr_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [BYTE_W-1:0]   rx_byte;
	logic [BYTE_W-1:0]   expect_id;

	modport source (output valid, output opcode, output rx_byte, output expect_id,
		input ready);
	modport sink (input valid, input opcode, input rx_byte, input expect_id,
		output ready);
endinterface

`default_nettype wire

[design/xcfr_result_if.sv]
// ----------------------------------------------------------------------------
// xcfr_result_if
// Result word channel: frame report or one payload byte of a delivered frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface xcfr_result_if;
	import xcfr_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [BYTE_W-1:0]   frame_type;
	logic [BYTE_W-1:0]   frame_id;
	logic [LEN_W-1:0]    payload_len;
	logic [BYTE_W-1:0]   payload_byte;
	logic [IDX_W-1:0]    byte_index;
	logic                last;
	logic                motor_active;

	modport source (output valid, output status, output frame_type, output frame_id,
		output payload_len, output payload_byte, output byte_index, output last,
		output motor_active, input ready);
	modport sink (input valid, input status, input frame_type, input frame_id,
		input payload_len, input payload_byte, input byte_index, input last,
		input motor_active, output ready);
endinterface

`default_nettype wire

[design/xcfr_front.sv]
// ----------------------------------------------------------------------------
// xcfr_front
// Parser: takes one input word a cycle while the job queue is not full, tracks
// the frame, the wait and the motor flag, and pushes a job for every frame outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	xcfr_item_if.sink                            item,
	input  wire logic                            cfg_we,
	input  wire logic [xcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [xcfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire xcfr_pkg::q_status_t             q_stat,
	output      logic                            push,
	output      xcfr_pkg::job_t                  push_job
);
	import xcfr_pkg::*;

	// configuration
	logic [BYTE_W-1:0] start_byte_q, response_type_q, event_type_q;
	logic [BYTE_W-1:0] started_id_q, stopped_id_q;
	logic [TICK_W-1:0] timeout_q;

	// parser state
	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] type_q, type_d, id_q, id_d, xor_q, xor_d;
	logic [LEN_W-1:0]  len_q, len_d, count_q, count_d;
	logic [TICK_W-1:0] idle_q, idle_d;
	logic              awaiting_q, awaiting_d, motor_q, motor_d;
	logic [BYTE_W-1:0] awaited_q, awaited_d;
	payload_t          store_q;

	logic              acc;
	logic              st_we;
	logic [IDX_W-1:0]  st_addr;
	logic [BYTE_W-1:0] b;
	logic [LEN_W-1:0]  count_inc;
	logic [TICK_W-1:0] idle_inc;
	status_t           job_status;

	assign item.ready = !q_stat.full;
	assign acc        = item.valid && !q_stat.full;
	assign b          = item.rx_byte;
	assign count_inc  = count_q + 1'b1;
	assign idle_inc   = (idle_q < IDLE_MAX) ? idle_q + 1'b1 : idle_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q    <= 8'd170;
			response_type_q <= 8'd2;
			event_type_q    <= 8'd3;
			started_id_q    <= 8'd1;
			stopped_id_q    <= 8'd2;
			timeout_q       <= 24'd50000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_BYTE:    start_byte_q    <= cfg_data[BYTE_W-1:0];
				REG_RESPONSE_TYPE: response_type_q <= cfg_data[BYTE_W-1:0];
				REG_EVENT_TYPE:    event_type_q    <= cfg_data[BYTE_W-1:0];
				REG_STARTED_ID:    started_id_q    <= cfg_data[BYTE_W-1:0];
				REG_STOPPED_ID:    stopped_id_q    <= cfg_data[BYTE_W-1:0];
				REG_TIMEOUT:       timeout_q       <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// next state and job generation
	always_comb begin
		phase_d    = phase_q;
		type_d     = type_q;
		id_d       = id_q;
		len_d      = len_q;
		count_d    = count_q;
		xor_d      = xor_q;
		idle_d     = idle_q;
		awaiting_d = awaiting_q;
		awaited_d  = awaited_q;
		motor_d    = motor_q;
		st_we      = 1'b0;
		st_addr    = count_q[IDX_W-1:0];
		push       = 1'b0;
		job_status = ST_OTHER;
		if (acc) begin
			case (opcode_t'(item.opcode))
				OP_BYTE: begin
					idle_d = '0;
					case (phase_q)
						PH_HUNT: begin
							if (b == start_byte_q) begin
								type_d  = '0;
								id_d    = '0;
								len_d   = '0;
								count_d = '0;
								xor_d   = '0;
								phase_d = PH_TYPE;
							end
						end
						PH_TYPE: begin
							type_d  = b;
							xor_d   = b;
							phase_d = PH_ID;
						end
						PH_ID: begin
							id_d    = b;
							xor_d   = xor_q ^ b;
							phase_d = PH_LEN;
						end
						PH_LEN: begin
							xor_d = xor_q ^ b;
							if (b > BYTE_W'(MAX_PAYLOAD)) begin
								len_d      = (b > BYTE_W'(LEN_SAT)) ? LEN_SAT : b[LEN_W-1:0];
								phase_d    = PH_HUNT;
								push       = 1'b1;
								job_status = ST_TOO_LONG;
							end else begin
								len_d   = b[LEN_W-1:0];
								count_d = '0;
								phase_d = (b == '0) ? PH_SUM : PH_DATA;
							end
						end
						PH_DATA: begin
							st_we   = (count_q < LEN_W'(MAX_PAYLOAD));
							count_d = count_inc;
							xor_d   = xor_q ^ b;
							if (count_inc >= len_q)
								phase_d = PH_SUM;
						end
						PH_SUM: begin
							phase_d = PH_HUNT;
							push    = 1'b1;
							if (b != xor_q) begin
								job_status = ST_BAD_SUM;
							end else if (type_q == response_type_q) begin
								if (awaiting_q && id_q == awaited_q) begin
									awaiting_d = 1'b0;
									job_status = ST_MATCHED;
								end else begin
									job_status = ST_UNEXPECTED;
								end
							end else if (type_q == event_type_q) begin
								if (id_q == started_id_q)
									motor_d = 1'b1;
								else if (id_q == stopped_id_q)
									motor_d = 1'b0;
								job_status = ST_EVENT;
							end else begin
								job_status = ST_OTHER;
							end
						end
						default: phase_d = PH_HUNT;
					endcase
				end
				OP_TICK: begin
					if (phase_q != PH_HUNT) begin
						if (idle_inc > timeout_q) begin
							phase_d    = PH_HUNT;
							idle_d     = '0;
							push       = 1'b1;
							job_status = ST_TIMEOUT;
						end else begin
							idle_d = idle_inc;
						end
					end
				end
				OP_ARM: begin
					awaiting_d = 1'b1;
					awaited_d  = item.expect_id;
				end
				OP_CANCEL: awaiting_d = 1'b0;
				default: ;
			endcase
		end
		push_job.status  = job_status;
		push_job.ftype   = type_q;
		push_job.fid     = id_q;
		push_job.len     = len_d;
		push_job.payload = store_q;
		push_job.motor   = motor_d;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			type_q     <= '0;
			id_q       <= '0;
			len_q      <= '0;
			count_q    <= '0;
			xor_q      <= '0;
			idle_q     <= '0;
			awaiting_q <= 1'b0;
			awaited_q  <= '0;
			motor_q    <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			type_q     <= type_d;
			id_q       <= id_d;
			len_q      <= len_d;
			count_q    <= count_d;
			xor_q      <= xor_d;
			idle_q     <= idle_d;
			awaiting_q <= awaiting_d;
			awaited_q  <= awaited_d;
			motor_q    <= motor_d;
		end
	end

	// payload buffer
	always_ff @(posedge clk) begin
		if (st_we)
			store_q[st_addr] <= b;
	end

endmodule

`default_nettype wire

[design/xcfr_queue.sv]
// ----------------------------------------------------------------------------
// xcfr_queue
// Two-entry job queue between the parser and the result emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire xcfr_pkg::job_t      push_job,
	input  wire logic                pop,
	output      xcfr_pkg::job_t      head,
	output      xcfr_pkg::q_status_t stat
);
	import xcfr_pkg::*;

	job_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign head       = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && stat.full |-> pop) else $error("job pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty) else $error("job popped from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");

endmodule

`default_nettype wire

[design/xcfr_back.sv]
// ----------------------------------------------------------------------------
// xcfr_back
// Result emitter: turns each job into one report word or one word per
// payload byte, through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire xcfr_pkg::job_t      head,
	input  wire xcfr_pkg::q_status_t q_stat,
	output      logic                pop,
	xcfr_result_if.source            result
);
	import xcfr_pkg::*;

	job_t             job_q;
	logic             job_valid_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;

	logic             adv, deliver, is_last;

	assign adv     = !out_valid_q || result.ready;
	assign deliver = (job_q.status == ST_MATCHED || job_q.status == ST_EVENT)
		&& job_q.len != '0;
	assign is_last = !deliver || (LEN_W'(idx_q) + 1'b1 == job_q.len);
	assign pop     = !q_stat.empty && (!job_valid_q || (adv && is_last));

	// current job and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (pop) begin
			job_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (job_valid_q && adv) begin
			if (is_last)
				job_valid_q <= 1'b0;
			else
				idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= head;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= job_valid_q;
	end

	always_ff @(posedge clk) begin
		if (adv && job_valid_q) begin
			result.status       <= job_q.status;
			result.frame_type   <= job_q.ftype;
			result.frame_id     <= job_q.fid;
			result.payload_len  <= job_q.len;
			result.payload_byte <= deliver ? job_q.payload[idx_q] : '0;
			result.byte_index   <= idx_q;
			result.last         <= is_last;
			result.motor_active <= job_q.motor;
		end
	end

	assign result.valid = out_valid_q;

	a_report_single: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q && !deliver |-> idx_q == '0) else $error("report word with index");
	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q && deliver |-> LEN_W'(idx_q) < job_q.len)
		else $error("byte index beyond frame length");
	a_last_frees_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q && adv && is_last && q_stat.empty |=> !job_valid_q)
		else $error("job kept after final word");

endmodule

`default_nettype wire

[design/xor_checked_frame_receiver.sv]
// Receives framed bytes (start, type, id, length, payload, XOR checksum) and
// reports each frame outcome. The parser takes one input word per cycle while
// the job queue is not full; the result emitter gives one result word per cycle
// while the result side is ready, one per payload byte of a delivered frame and
// one for a report. A two-entry job queue lies between them, so input words are
// refused only while two finished frames still wait for their results to drain;
// a job passes the queue, the emitter's job register and then its output register.
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// Top level: parser, job queue and result emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module xor_checked_frame_receiver (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	xcfr_item_if.sink                            item,
	xcfr_result_if.source                        result,
	input  wire logic                            cfg_we,
	input  wire logic [xcfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [xcfr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import xcfr_pkg::*;

	logic      push, pop;
	job_t      push_job, head;
	q_status_t q_stat;

	// frame parser
	xcfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	// job queue
	xcfr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.stat    (q_stat)
	);

	// result emitter
	xcfr_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.head  (head),
		.q_stat(q_stat),
		.pop   (pop),
		.result(result)
	);

endmodule

`default_nettype wire

[test/xor_checked_frame_receiver_tb.sv]
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_tb
// Self-checking bench for the XOR-checked frame receiver. A queue of line
// words (bytes, ticks, arm and cancel) feeds a bursty driver. Every accepted
// word runs through a deframing predictor. The monitor checks each result word
// against the oldest report still due. The phases run under several register
// settings, with random stalls and one long hold-off on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module xor_checked_frame_receiver_tb;
	import xcfr_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int SETTLE_GAP   = 8;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_WORDS  = 38;

	typedef struct packed {
		opcode_t           op;
		logic [BYTE_W-1:0] rx_byte;
		logic [BYTE_W-1:0] expect_id;
	} line_word_t;

	typedef struct packed {
		status_t           status;
		logic [BYTE_W-1:0] ftype;
		logic [BYTE_W-1:0] fid;
		logic [LEN_W-1:0]  len;
		logic [BYTE_W-1:0] pbyte;
		logic [IDX_W-1:0]  idx;
		logic              last;
		logic              motor;
	} frame_report_t;

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_ALTERNATE
	} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	xcfr_item_if   item_ch ();
	xcfr_result_if result_ch ();

	xor_checked_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// register mirror, at reset values
	logic [BYTE_W-1:0] cfg_start   = 8'd170;
	logic [BYTE_W-1:0] cfg_resp    = 8'd2;
	logic [BYTE_W-1:0] cfg_evt     = 8'd3;
	logic [BYTE_W-1:0] cfg_started = 8'd1;
	logic [BYTE_W-1:0] cfg_stopped = 8'd2;
	logic [TICK_W-1:0] cfg_timeout = 24'd50000;

	// predicted parser state
	phase_t            cur_phase   = PH_HUNT;
	logic [BYTE_W-1:0] frm_type    = '0;
	logic [BYTE_W-1:0] frm_id      = '0;
	logic [LEN_W-1:0]  frm_len     = '0;
	logic [BYTE_W-1:0] frm_data [MAX_PAYLOAD];
	logic [LEN_W-1:0]  frm_count   = '0;
	logic [BYTE_W-1:0] frm_xor     = '0;
	logic [TICK_W-1:0] quiet_ticks = '0;
	logic              resp_armed  = 1'b0;
	logic [BYTE_W-1:0] armed_id    = '0;
	logic              motor_on    = 1'b0;

	line_word_t    line_words [$];
	frame_report_t due_reports [$];
	line_word_t    offered_word;
	bit            offer_live = 1'b0;
	int            pushed_words = 0;
	int            fail_count = 0;
	int            run_cycles = 0;
	logic [BYTE_W-1:0] armed_hint = '0;

	// sender burst shaping
	int burst_left = 0;
	int gap_left   = 0;

	// receiver stall shaping
	bit         hold_req  = 1'b0;
	int         hold_left = 0;
	int         mode_left = 0;
	sink_mode_t stall_mode = SINK_OPEN;

	task automatic add_report(input status_t st, input logic [BYTE_W-1:0] pbyte,
			input logic [IDX_W-1:0] idx, input logic last);
		frame_report_t r;
		r.status = st;
		r.ftype  = frm_type;
		r.fid    = frm_id;
		r.len    = frm_len;
		r.pbyte  = pbyte;
		r.idx    = idx;
		r.last   = last;
		r.motor  = motor_on;
		due_reports.push_back(r);
	endtask

	// predictor: advance the deframer by one accepted word
	task automatic deframe(input line_word_t w);
		logic [BYTE_W-1:0] b;
		status_t st;
		int i;
		b = w.rx_byte;
		case (w.op)
		OP_BYTE: begin
			quiet_ticks = '0;
			case (cur_phase)
			PH_HUNT: begin
				if (b == cfg_start) begin
					frm_type  = '0;
					frm_id    = '0;
					frm_len   = '0;
					frm_count = '0;
					frm_xor   = '0;
					cur_phase = PH_TYPE;
				end
			end
			PH_TYPE: begin
				frm_type  = b;
				frm_xor   = b;
				cur_phase = PH_ID;
			end
			PH_ID: begin
				frm_id    = b;
				frm_xor   = frm_xor ^ b;
				cur_phase = PH_LEN;
			end
			PH_LEN: begin
				frm_xor = frm_xor ^ b;
				if (b > MAX_PAYLOAD) begin
					frm_len   = (b > 8'd31) ? LEN_SAT : b[LEN_W-1:0];
					cur_phase = PH_HUNT;
					add_report(ST_TOO_LONG, '0, '0, 1'b1);
				end else begin
					frm_len   = b[LEN_W-1:0];
					frm_count = '0;
					cur_phase = (b == 8'd0) ? PH_SUM : PH_DATA;
				end
			end
			PH_DATA: begin
				frm_data[frm_count[IDX_W-1:0]] = b;
				frm_count = frm_count + 1'b1;
				frm_xor   = frm_xor ^ b;
				if (frm_count >= frm_len)
					cur_phase = PH_SUM;
			end
			PH_SUM: begin
				cur_phase = PH_HUNT;
				if (b != frm_xor) begin
					add_report(ST_BAD_SUM, '0, '0, 1'b1);
				end else begin
					// sort the checked frame
					if (frm_type == cfg_resp) begin
						if (resp_armed && frm_id == armed_id) begin
							resp_armed = 1'b0;
							st = ST_MATCHED;
						end else begin
							st = ST_UNEXPECTED;
						end
					end else if (frm_type == cfg_evt) begin
						if (frm_id == cfg_started)
							motor_on = 1'b1;
						else if (frm_id == cfg_stopped)
							motor_on = 1'b0;
						st = ST_EVENT;
					end else begin
						st = ST_OTHER;
					end
					if ((st != ST_MATCHED && st != ST_EVENT) || frm_len == '0) begin
						add_report(st, '0, '0, 1'b1);
					end else begin
						for (i = 0; i < frm_len; i++)
							add_report(st, frm_data[i], i[IDX_W-1:0], i == frm_len - 1);
					end
				end
			end
			default: cur_phase = PH_HUNT;
			endcase
		end
		OP_TICK: begin
			// idle ticks only count while a frame is open
			if (cur_phase != PH_HUNT) begin
				if (quiet_ticks != IDLE_MAX)
					quiet_ticks = quiet_ticks + 1'b1;
				if (quiet_ticks > cfg_timeout) begin
					cur_phase   = PH_HUNT;
					quiet_ticks = '0;
					add_report(ST_TIMEOUT, '0, '0, 1'b1);
				end
			end
		end
		OP_ARM: begin
			resp_armed = 1'b1;
			armed_id   = w.expect_id;
		end
		default: resp_armed = 1'b0;
		endcase
	endtask

	task automatic push_word(input opcode_t op, input logic [BYTE_W-1:0] b,
			input logic [BYTE_W-1:0] eid);
		line_word_t w;
		w.op        = op;
		w.rx_byte   = b;
		w.expect_id = eid;
		line_words.push_back(w);
		pushed_words++;
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		push_word(OP_BYTE, b, BYTE_W'($urandom));
	endtask

	task automatic push_tick();
		push_word(OP_TICK, BYTE_W'($urandom), BYTE_W'($urandom));
	endtask

	// frame byte with the odd idle tick after it
	task automatic frame_byte(input logic [BYTE_W-1:0] b);
		push_byte(b);
		if ($urandom_range(0, 11) == 0)
			push_tick();
	endtask

	// frame with random content, sometimes too long, checksum now and then corrupted
	task automatic add_frame();
		logic [BYTE_W-1:0] t, id, n, sum, d;
		int k;
		case ($urandom_range(0, 2))
		0:       t = cfg_resp;
		1:       t = cfg_evt;
		default: t = BYTE_W'($urandom);
		endcase
		k = $urandom_range(0, 3);
		if (t == cfg_resp && k < 2)
			id = armed_hint;
		else if (k == 2)
			id = $urandom_range(0, 1) ? cfg_started : cfg_stopped;
		else
			id = BYTE_W'($urandom);
		k = $urandom_range(0, 19);
		if (k < 12)
			n = BYTE_W'($urandom_range(0, 4));
		else if (k < 17)
			n = BYTE_W'($urandom_range(5, 16));
		else if (k == 17)
			n = 8'd16;
		else begin
			case ($urandom_range(0, 3))
			0:       n = 8'd17;
			1:       n = 8'd31;
			2:       n = 8'd32;
			default: n = BYTE_W'($urandom_range(17, 255));
			endcase
		end
		frame_byte(cfg_start);
		frame_byte(t);
		frame_byte(id);
		frame_byte(n);
		if (n <= MAX_PAYLOAD) begin
			sum = t ^ id ^ n;
			for (k = 0; k < n; k++) begin
				d = BYTE_W'($urandom);
				sum = sum ^ d;
				frame_byte(d);
			end
			if ($urandom_range(0, 99) < 15)
				sum = sum ^ (8'h01 << $urandom_range(0, 7));
			push_byte(sum);
		end
	endtask

	// mostly frames, the rest arm, cancel, noise and abandoned frames
	task automatic run_phase(input int n_words);
		int target, r, k;
		target = pushed_words + n_words;
		while (pushed_words < target) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				armed_hint = BYTE_W'($urandom);
				push_word(OP_ARM, BYTE_W'($urandom), armed_hint);
			end else if (r < 14) begin
				push_word(OP_CANCEL, BYTE_W'($urandom), BYTE_W'($urandom));
			end else if (r < 22) begin
				if ($urandom_range(0, 1))
					push_byte(BYTE_W'($urandom));
				else
					push_tick();
			end else if (r < 30) begin
				push_byte(cfg_start);
				k = $urandom_range(0, 3);
				repeat (k) push_byte(BYTE_W'($urandom));
				repeat ((cfg_timeout < 8) ? cfg_timeout + 1 : 3) push_tick();
			end else begin
				add_frame();
			end
		end
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
		REG_START_BYTE:    cfg_start   = val[BYTE_W-1:0];
		REG_RESPONSE_TYPE: cfg_resp    = val[BYTE_W-1:0];
		REG_EVENT_TYPE:    cfg_evt     = val[BYTE_W-1:0];
		REG_STARTED_ID:    cfg_started = val[BYTE_W-1:0];
		REG_STOPPED_ID:    cfg_stopped = val[BYTE_W-1:0];
		REG_TIMEOUT:       cfg_timeout = val[TICK_W-1:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic program_regs(input logic [BYTE_W-1:0] sb, input logic [BYTE_W-1:0] rt,
			input logic [BYTE_W-1:0] et, input logic [BYTE_W-1:0] on_id,
			input logic [BYTE_W-1:0] off_id, input logic [TICK_W-1:0] tmo);
		set_reg(REG_START_BYTE, CFG_DATA_W'(sb));
		set_reg(REG_RESPONSE_TYPE, CFG_DATA_W'(rt));
		set_reg(REG_EVENT_TYPE, CFG_DATA_W'(et));
		set_reg(REG_STARTED_ID, CFG_DATA_W'(on_id));
		set_reg(REG_STOPPED_ID, CFG_DATA_W'(off_id));
		set_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
	endtask

	// sender pause: everything offered, every report back, parser quiet
	task automatic settle();
		while (line_words.size() != 0 || offer_live || due_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			if (fail_count < 40)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
			fail_count++;
		end
	endtask

	// stimulus and sequencing
	initial begin
		int waited;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		item_ch.valid     = 1'b0;
		item_ch.opcode    = OP_BYTE;
		item_ch.rx_byte   = '0;
		item_ch.expect_id = '0;
		result_ch.ready   = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: tick while hunting, arm, matched response, motor start event,
		// too long, bad checksum, cancel
		push_tick();
		push_word(OP_ARM, 8'h00, 8'hFF);
		push_byte(8'hAA); push_byte(8'h02); push_byte(8'hFF); push_byte(8'h02);
		push_byte(8'h00); push_byte(8'hFF); push_byte(8'h00);
		push_byte(8'hAA); push_byte(8'h03); push_byte(8'h01); push_byte(8'h00);
		push_byte(8'h02);
		push_byte(8'hAA); push_byte(8'h02); push_byte(8'h00); push_byte(8'hFF);
		push_byte(8'hAA); push_byte(8'h07); push_byte(8'h09); push_byte(8'h00);
		push_byte(8'h0F);
		push_word(OP_CANCEL, 8'hFF, 8'h00);
		settle();

		// directed: zero timeout, first tick in an open frame abandons it
		program_regs(8'd170, 8'd2, 8'd3, 8'd1, 8'd2, 24'd0);
		push_byte(8'hAA); push_byte(8'h03); push_tick();
		settle();

		// low and high register extremes
		program_regs(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 24'd3);
		run_phase(PHASE_WORDS);
		settle();

		// overlapping types and ids, no timeout, long hold-off on results
		program_regs(8'hFF, 8'h41, 8'h41, 8'h07, 8'h07, 24'hFFFFFF);
		hold_req = 1'b1;
		run_phase(PHASE_WORDS);
		settle();

		program_regs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
			BYTE_W'($urandom), BYTE_W'($urandom), TICK_W'($urandom_range(0, 4)));
		run_phase(PHASE_WORDS);
		settle();

		program_regs(8'd170, 8'd2, 8'd3, 8'd1, 8'd2, 24'd1);
		run_phase(PHASE_WORDS);

		// drain and look for stray results
		while (line_words.size() != 0 || offer_live)
			@(posedge clk);
		for (waited = 0; due_reports.size() != 0 && waited < DRAIN_LIMIT; waited++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (due_reports.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, due_reports.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// driver: word taken at the rising edge
	always @(posedge clk) begin
		if (arst_n && item_ch.valid && item_ch.ready) begin
			deframe(offered_word);
			offer_live = 1'b0;
		end
	end

	// driver: next word offered at the falling edge, in bursts
	always @(negedge clk) begin
		if (!offer_live) begin
			if (gap_left > 0) begin
				gap_left--;
				item_ch.valid <= 1'b0;
			end else if (arst_n && line_words.size() != 0) begin
				offered_word = line_words.pop_front();
				item_ch.opcode    <= offered_word.op;
				item_ch.rx_byte   <= offered_word.rx_byte;
				item_ch.expect_id <= offered_word.expect_id;
				item_ch.valid     <= 1'b1;
				offer_live = 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left--;
				end
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// receiver stalls: long hold when asked, otherwise a changing pattern
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = sink_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(20, 120);
			end
			mode_left--;
			case (stall_mode)
			SINK_OPEN:      result_ch.ready <= 1'b1;
			SINK_COIN:      result_ch.ready <= ($urandom_range(0, 1) == 1);
			SINK_SPARSE:    result_ch.ready <= ($urandom_range(0, 3) == 0);
			default:        result_ch.ready <= mode_left[0];
			endcase
		end
	end

	// monitor: compare each result word with the oldest report due
	always @(posedge clk) begin
		frame_report_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (due_reports.size() == 0) begin
				if (fail_count < 40)
					$display("%0t: result with nothing expected, status %0d type %0d id %0d",
						$time, result_ch.status, result_ch.frame_type, result_ch.frame_id);
				fail_count++;
			end else begin
				want = due_reports.pop_front();
				check_field("status", 32'(want.status), 32'(result_ch.status));
				check_field("frame_type", 32'(want.ftype), 32'(result_ch.frame_type));
				check_field("frame_id", 32'(want.fid), 32'(result_ch.frame_id));
				check_field("payload_len", 32'(want.len), 32'(result_ch.payload_len));
				check_field("payload_byte", 32'(want.pbyte), 32'(result_ch.payload_byte));
				check_field("byte_index", 32'(want.idx), 32'(result_ch.byte_index));
				check_field("last", 32'(want.last), 32'(result_ch.last));
				check_field("motor_active", 32'(want.motor), 32'(result_ch.motor_active));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		run_cycles++;
		if (run_cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
